@@ design/tcaw_pkg.sv @@
// Shared types and constants for the texture column address walker.
// Used by the divider, datapath, controller and top level; no dependencies.
package tcaw_pkg;

   // Width of the shared iterative divider (dividend, divisor, quotient).
   localparam int DivW = 64;

   // Configuration register indexes.
   localparam logic CSR_WALL_SPAN        = 1'b0;
   localparam logic CSR_FRAME_LINE_BYTES = 1'b1;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_PIXEL,
      OP_QSTART,
      OP_QEND,
      OP_MFL,
      OP_MOFF,
      OP_MSN,
      OP_OSTART,
      OP_OEND,
      OP_SSTART,
      OP_SEND,
      OP_MN,
      OP_MD,
      OP_RSTART,
      OP_MR,
      OP_CSTART,
      OP_CEND
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic pixels_zero;
   } status_type;

endpackage

@@ design/tcaw_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tcaw_pkg for its width.
module tcaw_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tcaw_pkg::DivW-1:0]  dividend,
   input  logic [tcaw_pkg::DivW-1:0]  divisor,
   output logic                       done,
   output logic [tcaw_pkg::DivW-1:0]  quotient,
   output logic [tcaw_pkg::DivW-1:0]  remainder
);

   localparam int W  = tcaw_pkg::DivW;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  quo_ff, rem_ff, den_ff;
   logic [W:0]    shifted;
   logic [W+1:0]  diff;
   logic [W-1:0]  rem_next;

   always_comb begin
      shifted  = {rem_ff, quo_ff[W-1]};
      diff     = {1'b0, shifted} - {2'b00, den_ff};
      rem_next = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = '0;
      end else if (busy_ff) begin
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[W-2:0], ~diff[W+1]};
         rem_ff <= rem_next;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ design/tcaw_datapath.sv @@
// Datapath: configuration registers, column setup arithmetic, pixel walker.
// Depends on tcaw_pkg and instantiates tcaw_divider.
module tcaw_datapath #(
   parameter int WINDOW_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcaw_pkg::cmd_type    cmd,
   output tcaw_pkg::status_type status,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [31:0]          csr_data,
   input  logic [10:0]          req_pixels_below,
   input  logic [10:0]          req_pixels_above,
   input  logic [31:0]          req_corner_dist,
   input  logic [31:0]          req_player_height,
   input  logic [31:0]          req_tex_base,
   input  logic [10:0]          req_tex_width,
   input  logic [10:0]          req_tex_height,
   input  logic [15:0]          req_tex_line_bytes,
   input  logic [5:0]           req_tex_bits_per_pixel,
   input  logic [31:0]          req_dest_address,
   output logic [31:0]          rsp_texel_address,
   output logic [31:0]          rsp_frame_address,
   output logic                 rsp_last_pixel
);

   localparam int W = tcaw_pkg::DivW;
   localparam logic signed [13:0] WinS    = 14'(WINDOW_HEIGHT);
   localparam logic [12:0]        WinU    = 13'(WINDOW_HEIGHT);
   localparam logic [12:0]        HalfWin = 13'(WINDOW_HEIGHT / 2);

   // Configuration and architectural state.
   logic [31:0]        wall_span_ff;
   logic [15:0]        frame_line_bytes_ff;
   logic [31:0]        column_base_ff;
   logic signed [31:0] row_position_ff;
   logic signed [31:0] row_step_ff;
   logic [11:0]        pixels_left_ff;
   logic [31:0]        frame_pointer_ff;
   logic [15:0]        row_bytes_ff;
   logic [10:0]        row_limit_ff;

   // Setup working registers.
   logic [10:0]        ae_ff, dx_ff, dyc_ff;
   logic [31:0]        ph_ff, cdist_ff, tbase_ff;
   logic [5:0]         bpp_ff;
   logic signed [33:0] f_ff;
   logic signed [45:0] fl_ff;
   logic signed [63:0] pnum_ff, snum_ff;
   logic [24:0]        sden_ff;
   logic               neg_ff;
   logic [42:0]        n_ff, d_ff;
   logic [53:0]        rdx_ff;
   logic [31:0]        rsp_texel_ff, rsp_frame_ff;
   logic               rsp_last_ff;

   // Divider.
   logic [W-1:0] div_num, div_den, div_quo, div_rem;
   logic         div_done;

   // Combinational helpers.
   logic [31:0]        wh;
   logic [31:0]        qs;
   logic               big_ae, big_above;
   logic [11:0]        acount;
   logic signed [13:0] m2;
   logic signed [45:0] fl_prod;
   logic signed [63:0] pnum_prod, snum_prod;
   logic [W-1:0]       pnum_abs, snum_abs;
   logic [31:0]        off_val, step_val;
   logic [16:0]        colbytes;
   logic [14:0]        r16;
   logic [10:0]        row;
   logic [26:0]        tex_off;
   logic signed [32:0] rp_sum;
   logic signed [31:0] rp_next;

   tcaw_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      wh        = (wall_span_ff == '0) ? 32'd1 : wall_span_ff;
      qs        = (|div_quo[63:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
      big_ae    = {1'b0, ae_ff, 1'b0} > WinU;
      big_above = {1'b0, req_pixels_above, 1'b0} > WinU;
      acount    = big_above ? HalfWin[11:0] : {1'b0, req_pixels_above};
      m2        = $signed({2'b00, ae_ff, 1'b0}) - WinS;
      fl_prod   = f_ff * $signed({1'b0, row_limit_ff});
      pnum_prod = fl_ff * m2;
      snum_prod = fl_ff * WinS;
      pnum_abs  = pnum_ff[63] ? W'(-pnum_ff) : W'(pnum_ff);
      snum_abs  = snum_ff[63] ? W'(-snum_ff) : W'(snum_ff);
      // Start offset clamps to [0, max]; step saturates to signed 32 bits.
      off_val   = neg_ff ? 32'd0
                  : ((div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0]);
      if (neg_ff) begin
         step_val = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - div_quo[31:0]);
      end else begin
         step_val = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
      end
      colbytes  = 17'(div_quo[10:0]) * 17'(bpp_ff);
      // Row lookup: negative positions read row zero, high rows stop at the limit.
      r16       = row_position_ff[30:16];
      if (row_position_ff[31]) begin
         row = '0;
      end else if (r16 > {4'b0000, row_limit_ff}) begin
         row = row_limit_ff;
      end else begin
         row = r16[10:0];
      end
      tex_off   = 27'(row_bytes_ff) * 27'(row);
      rp_sum    = {row_position_ff[31], row_position_ff} + {row_step_ff[31], row_step_ff};
      if (rp_sum[32] != rp_sum[31]) begin
         rp_next = rp_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         rp_next = rp_sum[31:0];
      end
      unique case (cmd.op)
         tcaw_pkg::OP_QSTART: begin
            div_num = {16'h0000, ph_ff, 16'h0000};
            div_den = W'(wh);
         end
         tcaw_pkg::OP_OSTART: begin
            div_num = pnum_abs;
            div_den = W'({ae_ff, 1'b0});
         end
         tcaw_pkg::OP_SSTART: begin
            div_num = snum_abs;
            div_den = W'(sden_ff);
         end
         tcaw_pkg::OP_RSTART: begin
            div_num = W'(n_ff);
            div_den = W'(d_ff);
         end
         tcaw_pkg::OP_CSTART: begin
            div_num = W'(rdx_ff);
            div_den = W'(d_ff);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   // Configuration and walker state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wall_span_ff        <= 32'd65536;
         frame_line_bytes_ff <= 16'd4096;
         column_base_ff      <= '0;
         row_position_ff     <= '0;
         row_step_ff         <= '0;
         pixels_left_ff      <= '0;
         frame_pointer_ff    <= '0;
         row_bytes_ff        <= '0;
         row_limit_ff        <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               tcaw_pkg::CSR_WALL_SPAN:        wall_span_ff        <= csr_data;
               tcaw_pkg::CSR_FRAME_LINE_BYTES: frame_line_bytes_ff <= csr_data[15:0];
               default:                        ;
            endcase
         end
         unique case (cmd.op)
            tcaw_pkg::OP_LOAD: begin
               row_limit_ff     <= (req_tex_height == '0) ? 11'd0 : req_tex_height - 11'd1;
               pixels_left_ff   <= 12'({1'b0, req_pixels_below} + acount);
               frame_pointer_ff <= req_dest_address;
               row_bytes_ff     <= req_tex_line_bytes;
            end
            tcaw_pkg::OP_OEND: row_position_ff <= off_val;
            tcaw_pkg::OP_SEND: row_step_ff     <= step_val;
            tcaw_pkg::OP_CEND: column_base_ff  <= tbase_ff + 32'(colbytes >> 3);
            tcaw_pkg::OP_PIXEL: begin
               frame_pointer_ff <= frame_pointer_ff + 32'(frame_line_bytes_ff);
               row_position_ff  <= rp_next;
               pixels_left_ff   <= pixels_left_ff - 12'd1;
            end
            default: ;
         endcase
      end
   end

   // Setup working registers and the result register.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         tcaw_pkg::OP_LOAD: begin
            ae_ff    <= (req_pixels_above == '0) ? 11'd1 : req_pixels_above;
            dx_ff    <= req_tex_width;
            dyc_ff   <= (req_tex_height == '0) ? 11'd1 : req_tex_height;
            ph_ff    <= req_player_height;
            cdist_ff <= req_corner_dist;
            tbase_ff <= req_tex_base;
            bpp_ff   <= req_tex_bits_per_pixel;
         end
         tcaw_pkg::OP_QEND: f_ff <= 34'sd65536 - $signed({2'b00, qs});
         tcaw_pkg::OP_MFL:  fl_ff <= fl_prod;
         tcaw_pkg::OP_MOFF: pnum_ff <= pnum_prod;
         tcaw_pkg::OP_MSN: begin
            snum_ff <= big_ae ? snum_prod : 64'(fl_ff);
            sden_ff <= big_ae ? 25'({ae_ff, 1'b0}) * 25'(HalfWin) : 25'(ae_ff);
         end
         tcaw_pkg::OP_OSTART: neg_ff <= pnum_ff[63];
         tcaw_pkg::OP_SSTART: neg_ff <= snum_ff[63];
         tcaw_pkg::OP_MN: n_ff <= 43'(cdist_ff) * 43'(dx_ff);
         tcaw_pkg::OP_MD: d_ff <= 43'(wh) * 43'(dyc_ff);
         tcaw_pkg::OP_MR: rdx_ff <= 54'(div_rem[42:0]) * 54'(dx_ff);
         tcaw_pkg::OP_PIXEL: begin
            rsp_texel_ff <= column_base_ff + 32'(tex_off);
            rsp_frame_ff <= frame_pointer_ff;
            rsp_last_ff  <= (pixels_left_ff == 12'd1);
         end
         default: ;
      endcase
   end

   assign status.div_done    = div_done;
   assign status.pixels_zero = (pixels_left_ff == '0);
   assign rsp_texel_address  = rsp_texel_ff;
   assign rsp_frame_address  = rsp_frame_ff;
   assign rsp_last_pixel     = rsp_last_ff;

endmodule

@@ design/tcaw_ctrl.sv @@
// Controller: request handshake, result valid and the column setup sequence.
// Depends on tcaw_pkg for command and status types.
module tcaw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tcaw_pkg::status_type status,
   output tcaw_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_QS, ST_QW, ST_MFL, ST_MOFF, ST_MSN, ST_OS, ST_OW,
      ST_SS, ST_SW, ST_MN, ST_MD, ST_RS, ST_RW, ST_MR, ST_CS, ST_CW
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = tcaw_pkg::OP_NONE;
      cmd.div_start = 1'b0;
      req_stall     = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept        = req_valid && !req_stall;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_kind) begin
                  cmd.op   = tcaw_pkg::OP_LOAD;
                  state_in = ST_QS;
               end else if (!status.pixels_zero) begin
                  cmd.op       = tcaw_pkg::OP_PIXEL;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_QS: begin
            cmd.op = tcaw_pkg::OP_QSTART; cmd.div_start = 1'b1; state_in = ST_QW;
         end
         ST_QW: if (status.div_done) begin
            cmd.op = tcaw_pkg::OP_QEND; state_in = ST_MFL;
         end
         ST_MFL:  begin cmd.op = tcaw_pkg::OP_MFL;  state_in = ST_MOFF; end
         ST_MOFF: begin cmd.op = tcaw_pkg::OP_MOFF; state_in = ST_MSN;  end
         ST_MSN:  begin cmd.op = tcaw_pkg::OP_MSN;  state_in = ST_OS;   end
         ST_OS: begin
            cmd.op = tcaw_pkg::OP_OSTART; cmd.div_start = 1'b1; state_in = ST_OW;
         end
         ST_OW: if (status.div_done) begin
            cmd.op = tcaw_pkg::OP_OEND; state_in = ST_SS;
         end
         ST_SS: begin
            cmd.op = tcaw_pkg::OP_SSTART; cmd.div_start = 1'b1; state_in = ST_SW;
         end
         ST_SW: if (status.div_done) begin
            cmd.op = tcaw_pkg::OP_SEND; state_in = ST_MN;
         end
         ST_MN: begin cmd.op = tcaw_pkg::OP_MN; state_in = ST_MD; end
         ST_MD: begin cmd.op = tcaw_pkg::OP_MD; state_in = ST_RS; end
         ST_RS: begin
            cmd.op = tcaw_pkg::OP_RSTART; cmd.div_start = 1'b1; state_in = ST_RW;
         end
         ST_RW: if (status.div_done) state_in = ST_MR;
         ST_MR: begin cmd.op = tcaw_pkg::OP_MR; state_in = ST_CS; end
         ST_CS: begin
            cmd.op = tcaw_pkg::OP_CSTART; cmd.div_start = 1'b1; state_in = ST_CW;
         end
         ST_CW: if (status.div_done) begin
            cmd.op = tcaw_pkg::OP_CEND; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/texture_column_address_walker_top.sv @@
// Texture column address walker, top level.
// Pixel request: one per cycle when the result side keeps up; result valid next cycle.
// Column start request: stalls requests while setup runs five passes of the shared divider
// plus six multiply steps; the next request is accepted once setup is back in idle.
// Synchronous active-high reset clears all walker state; the wall span register resets
// to 1.0 (16.16) and frame_line_bytes to 4096.
module texture_column_address_walker_top #(
   parameter int WINDOW_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [10:0] req_pixels_below,
   input  logic [10:0] req_pixels_above,
   input  logic [31:0] req_corner_dist,
   input  logic [31:0] req_player_height,
   input  logic [31:0] req_tex_base,
   input  logic [10:0] req_tex_width,
   input  logic [10:0] req_tex_height,
   input  logic [15:0] req_tex_line_bytes,
   input  logic [5:0]  req_tex_bits_per_pixel,
   input  logic [31:0] req_dest_address,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_texel_address,
   output logic [31:0] rsp_frame_address,
   output logic        rsp_last_pixel,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   tcaw_pkg::cmd_type    cmd;
   tcaw_pkg::status_type status;

   // Configuration is to be written only while idle; the block does not enforce it, so always take it.
   assign csr_ready = 1'b1;

   // Controller: owns the request and result handshakes and steps the datapath through setup.
   tcaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: holds the column state, the divider and the result register.
   tcaw_datapath #(
      .WINDOW_HEIGHT (WINDOW_HEIGHT)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_pixels_below       (req_pixels_below),
      .req_pixels_above       (req_pixels_above),
      .req_corner_dist        (req_corner_dist),
      .req_player_height      (req_player_height),
      .req_tex_base           (req_tex_base),
      .req_tex_width          (req_tex_width),
      .req_tex_height         (req_tex_height),
      .req_tex_line_bytes     (req_tex_line_bytes),
      .req_tex_bits_per_pixel (req_tex_bits_per_pixel),
      .req_dest_address       (req_dest_address),
      .rsp_texel_address      (rsp_texel_address),
      .rsp_frame_address      (rsp_frame_address),
      .rsp_last_pixel         (rsp_last_pixel)
   );

   // A column start request holds off the next request while setup runs.
   a_start_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_kind |=> req_stall)
      else $error("column setup did not stall the request channel");

   // A new result appears only after a pixel request was accepted.
   a_rsp_from_pixel: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_kind))
      else $error("result raised without an accepted pixel request");

   // A divider start never fires while the request side is open.
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> req_stall)
      else $error("divider started while requests were accepted");

endmodule
